@@ rtl/core/huffman_bit_serial_decoder_unit_defines.svh @@
// assertion macros used by the decoder back end
// depends on nothing; the using module supplies clk and arst_n
`ifndef HUFFMAN_BIT_SERIAL_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_BIT_SERIAL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HBSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HBSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hbsd_pkg.sv @@
// shared types and constants of the bit-serial huffman decoder
// depends on nothing
package hbsd_pkg;

	// code table geometry
	localparam int MAX_CODE_LEN = 12;
	localparam int TREE_DEPTH   = 8192;
	localparam int ADDR_W       = $clog2(TREE_DEPTH);
	localparam int NEXT_W       = ADDR_W + 1;
	localparam int LOAD_W       = MAX_CODE_LEN + 1;
	localparam int LEVEL_END    = (1 << (MAX_CODE_LEN + 1)) - 1;
	localparam int WALK_BOUND   = (LEVEL_END < TREE_DEPTH) ? LEVEL_END : TREE_DEPTH;

	// field widths
	localparam int SYM_W  = 8;
	localparam int CODE_W = 12;
	localparam int LEN_W  = 4;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// one classified word for the back end
	typedef struct packed {
		logic              is_load;
		logic [ADDR_W-1:0] addr;
		logic [SYM_W-1:0]  symbol;
		logic              coded_bit;
	} hbsd_op_t;

endpackage

@@ rtl/core/hbsd_front.sv @@
// front end: accepts input words, drops void loads, computes load addresses
// depends on hbsd_pkg
module hbsd_front import hbsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hold,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [SYM_W-1:0]  symbol_in,
	input  logic [CODE_W-1:0] code_value,
	input  logic [LEN_W-1:0]  code_length,
	input  logic              coded_bit,
	output logic              push_valid,
	input  logic              push_ready,
	output hbsd_op_t          push_op
);

	logic              valid_s1;
	hbsd_op_t          op_s1;
	logic [LOAD_W-1:0] base;
	logic [LOAD_W-1:0] idx;
	logic              len_ok;
	logic              idx_ok;
	logic              keep;
	logic              in_fire;
	logic              push_fire;

	// heap index of a code: level base plus masked codeword
	always_comb begin
		base   = (LOAD_W'(1) << code_length) - LOAD_W'(1);
		idx    = base + (LOAD_W'(code_value) & base);
		len_ok = (code_length != '0) && (32'(code_length) <= MAX_CODE_LEN);
		idx_ok = 32'(idx) < TREE_DEPTH;
		keep   = (command == CMD_DECODE) || (len_ok && idx_ok);
	end

	assign push_fire  = valid_s1 && push_ready;
	assign in_ready   = !hold && (!valid_s1 || push_ready);
	assign in_fire    = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= keep;
		end else if (push_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1.is_load   <= (command == CMD_LOAD);
			op_s1.addr      <= ADDR_W'(idx);
			op_s1.symbol    <= symbol_in;
			op_s1.coded_bit <= coded_bit;
		end
	end

endmodule

@@ rtl/core/hbsd_queue.sv @@
// two-entry queue that decouples the front end from the back end
// depends on hbsd_pkg
module hbsd_queue import hbsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  hbsd_op_t push_op,
	output logic     pop_valid,
	input  logic     pop_ready,
	output hbsd_op_t pop_op
);

	hbsd_op_t          entry_q [QUEUE_DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push_fire;
	logic              pop_fire;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ rtl/core/hbsd_back.sv @@
// back end: tree memory with clearing pass, tree walk and output register
// depends on hbsd_pkg and huffman_bit_serial_decoder_unit_defines.svh
`include "huffman_bit_serial_decoder_unit_defines.svh"
module hbsd_back import hbsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	output logic             clearing,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  hbsd_op_t         pop_op,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SYM_W-1:0] symbol_out,
	output logic             walk_error
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [SYM_W-1:0]  tree_mem [TREE_DEPTH];
	logic [SYM_W-1:0]  rd_data_q;
	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] walk_q;
	logic [ADDR_W-1:0] walk_d;
	logic [ADDR_W-1:0] next_q;
	logic [NEXT_W-1:0] next;
	logic              step_err;
	logic              out_valid_q;
	logic [SYM_W-1:0]  sym_q;
	logic              err_q;
	logic              out_free;
	logic              emit;
	logic [SYM_W-1:0]  emit_sym;
	logic              emit_err;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [SYM_W-1:0]  mem_wdata;
	logic              mem_re;

	assign clearing   = state_q == ST_CLEAR;
	assign out_valid  = out_valid_q;
	assign symbol_out = sym_q;
	assign walk_error = err_q;
	assign out_free   = !out_valid_q || out_ready;

	// child index of the current node
	always_comb begin
		next     = {walk_q, 1'b0} + NEXT_W'(1) + NEXT_W'(pop_op.coded_bit);
		step_err = 32'(next) >= WALK_BOUND;
	end

	// walk sequencer
	always_comb begin
		state_d   = state_q;
		walk_d    = walk_q;
		pop_ready = 1'b0;
		emit      = 1'b0;
		emit_sym  = '0;
		emit_err  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pop_op.addr;
		mem_wdata = pop_op.symbol;
		mem_re    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ADDR_W'(TREE_DEPTH - 1)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (pop_valid) begin
					if (pop_op.is_load) begin
						pop_ready = 1'b1;
						mem_we    = 1'b1;
					end else if (step_err) begin
						if (out_free) begin
							pop_ready = 1'b1;
							emit      = 1'b1;
							emit_err  = 1'b1;
							walk_d    = '0;
						end
					end else begin
						pop_ready = 1'b1;
						mem_re    = 1'b1;
						state_d   = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				if (rd_data_q != '0) begin
					if (out_free) begin
						emit     = 1'b1;
						emit_sym = rd_data_q;
						walk_d   = '0;
						state_d  = ST_RUN;
					end
				end else begin
					walk_d  = next_q;
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word and pending child index
	always_ff @(posedge clk) begin
		if (emit) begin
			sym_q <= emit_sym;
			err_q <= emit_err;
		end
		if (mem_re) begin
			next_q <= ADDR_W'(next);
		end
	end

	// tree memory, one access a cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= tree_mem[next[ADDR_W-1:0]];
		end
	end

	`HBSD_ASSERT_NOW(a_no_pop_in_clear, state_q == ST_CLEAR, !pop_ready, "pop during clear")
	`HBSD_ASSERT_NOW(a_walk_bound, 1'b1, 32'(walk_q) < WALK_BOUND, "walk index out of tree")
	`HBSD_ASSERT_NOW(a_one_access, mem_we, !mem_re, "memory read and write in one cycle")
	`HBSD_ASSERT_NEXT(a_read_waits, mem_re, state_q == ST_WAIT, "tree read not followed by wait")

endmodule

@@ rtl/core/huffman_bit_serial_decoder_unit.sv @@
// a decoded symbol passes the front stage register, a queue entry, the tree memory read
// and the output register, an error skips the read; a decode bit is taken only after the
// read for the previous bit has decided the walk node; one load word per cycle when not stalled
// reset: walk returns to the root, then a clearing pass zeroes all 8192 tree memory words,
// with in_ready low throughout
module huffman_bit_serial_decoder_unit import hbsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [SYM_W-1:0]  symbol_in,
	input  logic [CODE_W-1:0] code_value,
	input  logic [LEN_W-1:0]  code_length,
	input  logic              coded_bit,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SYM_W-1:0]  symbol_out,
	output logic              walk_error
);

	logic     clearing;
	logic     push_valid;
	logic     push_ready;
	hbsd_op_t push_op;
	logic     pop_valid;
	logic     pop_ready;
	hbsd_op_t pop_op;

	// classify incoming words
	hbsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.hold        (clearing),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.symbol_in   (symbol_in),
		.code_value  (code_value),
		.code_length (code_length),
		.coded_bit   (coded_bit),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_op     (push_op)
	);

	// decoupling queue
	hbsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	// tree store and walk
	hbsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol_out (symbol_out),
		.walk_error (walk_error)
	);

endmodule
